// ----- rtl/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue unit
// Holds the ring depth, derived widths, command and status codes, the
// classified operation passed from the front part to the back part, and the
// ring index helper.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Ring geometry (legal depth range is 2 to 31).
  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // Beat field widths.
  localparam int CMD_W   = 3;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 5;

  // Command queue between the front and back parts.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 2) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Command codes on in_command.
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST       = 3'd4;

  // Status codes on out_status.
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW   = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW  = 2'd2;
  localparam logic [STAT_W-1:0] ST_LIST_EMPTY = 2'd3;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_REAR,
    OP_POP_FRONT,
    OP_POP_REAR,
    OP_LIST
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [DATA_W-1:0]  value;
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_POP,
    BK_LIST
  } bk_state_t;

  // Ring position a + b, with both operands below DEPTH.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(DEPTH)) begin
      s = s - (IDX_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// ----- rtl/double_ended_queue_unit.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_unit: double-ended queue of signed 32-bit words
// A ring buffer deque with push and pop at either end and a list command
// that streams the stored words from front to rear.
// ----------------------------------------------------------------------------
//
//   Channel  | Ports                                   | Handshake
//   ---------+-----------------------------------------+----------------------
//   input    | in_command, in_value                    | start high, busy low
//   result   | out_value_res, out_status, out_last,    | out_valid, one cycle,
//            | out_occupancy                           | cannot be held off
//
// Steps: the back part settles a push or a failed pop in its idle state; a
// pop does one ring RAM read and then gives the result; a list of N words
// issues one read per word, since the single RAM read port delivers one word
// per cycle. An empty list is settled in the idle state. Results appear in the
// cycle after the back part decides them.
// Reset: synchronous and active low; it clears the head, the word count and
// the command queue. The ring RAM is not cleared, since a word is only read
// after it was pushed.
// Stalls: a two-beat command queue sits between intake and execution, so
// busy rises only while that queue is full, e.g. during a long list walk.
// The receiver cannot stall the result channel.
//
module double_ended_queue_unit import dq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_value_res,
  output logic [STAT_W-1:0]        out_status,
  output logic                     out_last,
  output logic [OCC_W-1:0]         out_occupancy
);

  // Operation queue between the front and back parts.
  logic              q_valid;
  logic              q_pop;
  op_t               q_op;
  logic [DATA_W-1:0] value_res;

  // The front part takes one beat per cycle while its queue has room and
  // drops the unused command codes.
  dq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_command (in_command),
    .in_value   (in_value),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .q_pop      (q_pop)
  );

  // The back part owns the ring state and produces every result beat.
  dq_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_op          (q_op),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_value_res (value_res),
    .out_status    (out_status),
    .out_last      (out_last),
    .out_occupancy (out_occupancy)
  );

  assign out_value_res = signed'(value_res);

endmodule

// ----- rtl/dq_ram.sv -----
// ----------------------------------------------------------------------------
// dq_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/dq_front.sv -----
// ----------------------------------------------------------------------------
// dq_front: command intake and classification
// Takes input beats, turns command codes into operations, drops unused
// codes, and holds operations in a short queue for the back part.
// ----------------------------------------------------------------------------
module dq_front import dq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [DATA_W-1:0] in_value,
  output logic              q_valid,
  output op_t               q_op,
  input  logic              q_pop
);

  op_t               slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              accept;
  logic              known;
  logic              push;
  op_t               op_in;

  assign busy   = (cnt_r == QCNT_W'(QDEPTH));
  assign accept = start && !busy;

  always_comb begin
    known       = 1'b1;
    op_in.value = in_value;
    case (in_command)
      CMD_PUSH_FRONT: op_in.kind = OP_PUSH_FRONT;
      CMD_PUSH_REAR:  op_in.kind = OP_PUSH_REAR;
      CMD_POP_FRONT:  op_in.kind = OP_POP_FRONT;
      CMD_POP_REAR:   op_in.kind = OP_POP_REAR;
      CMD_LIST:       op_in.kind = OP_LIST;
      default: begin
        op_in.kind = OP_LIST;
        known      = 1'b0;
      end
    endcase
  end

  // Unused command codes are taken and then forgotten.
  assign push = accept && known;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= op_in;
    end
  end

  assign q_valid = (cnt_r != '0);
  assign q_op    = slot_r[rd_ptr_r];

endmodule

// ----- rtl/dq_back.sv -----
// ----------------------------------------------------------------------------
// dq_back: ring buffer execution
// Keeps the head position and word count, drives the ring RAM, and forms
// the result beats for pushes, pops and list walks.
// ----------------------------------------------------------------------------
module dq_back import dq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  op_t               q_op,
  output logic              q_pop,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_value_res,
  output logic [STAT_W-1:0] out_status,
  output logic              out_last,
  output logic [OCC_W-1:0]  out_occupancy
);

  bk_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   walk_r, walk_nxt;

  logic               valid_r, valid_nxt;
  logic [DATA_W-1:0]  value_r, value_nxt;
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic               last_r, last_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [IDX_W-1:0]   ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;
  logic               full;
  logic               empty;

  dq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_op.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    walk_nxt   = walk_r;
    valid_nxt  = 1'b0;
    value_nxt  = '0;
    status_nxt = ST_OK;
    last_nxt   = 1'b1;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = head_r;
    ram_raddr  = head_r;

    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          valid_nxt = 1'b1;
          case (q_op.kind)
            OP_PUSH_FRONT: begin
              if (full) begin
                status_nxt = ST_OVERFLOW;
              end else begin
                head_nxt  = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - 1'b1;
                ram_we    = 1'b1;
                ram_waddr = head_nxt;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_PUSH_REAR: begin
              if (full) begin
                status_nxt = ST_OVERFLOW;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = wrap_add(head_r, IDX_W'(count_r));
                count_nxt = count_r + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                status_nxt = ST_UNDERFLOW;
              end else begin
                // Word comes back from the RAM next cycle.
                valid_nxt = 1'b0;
                ram_raddr = head_r;
                head_nxt  = wrap_add(head_r, IDX_W'(1));
                count_nxt = count_r - 1'b1;
                state_nxt = BK_POP;
              end
            end
            OP_POP_REAR: begin
              if (empty) begin
                status_nxt = ST_UNDERFLOW;
              end else begin
                valid_nxt = 1'b0;
                ram_raddr = wrap_add(head_r, IDX_W'(count_r - 1'b1));
                count_nxt = count_r - 1'b1;
                state_nxt = BK_POP;
              end
            end
            OP_LIST: begin
              if (empty) begin
                status_nxt = ST_LIST_EMPTY;
              end else begin
                valid_nxt = 1'b0;
                ram_raddr = head_r;
                walk_nxt  = CNT_W'(1);
                state_nxt = BK_LIST;
              end
            end
            default: begin
              valid_nxt = 1'b0;
            end
          endcase
        end
      end
      BK_POP: begin
        valid_nxt = 1'b1;
        value_nxt = ram_rdata;
        state_nxt = BK_IDLE;
      end
      BK_LIST: begin
        // walk_r counts reads issued so far; the beat with walk_r equal to
        // the count is the final word.
        valid_nxt = 1'b1;
        value_nxt = ram_rdata;
        last_nxt  = (walk_r == count_r);
        if (walk_r == count_r) begin
          state_nxt = BK_IDLE;
        end else begin
          ram_raddr = wrap_add(head_r, IDX_W'(walk_r));
          walk_nxt  = walk_r + 1'b1;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    occ_nxt = OCC_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      head_r  <= '0;
      count_r <= '0;
      walk_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      walk_r  <= walk_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r  <= value_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
    occ_r    <= occ_nxt;
  end

  assign out_valid     = valid_r;
  assign out_value_res = value_r;
  assign out_status    = status_r;
  assign out_last      = last_r;
  assign out_occupancy = occ_r;

endmodule

// ----- rtl/dq_checker.sv -----
// ----------------------------------------------------------------------------
// dq_checker: port-level checks for the double-ended queue unit
// Watches the result channel for beats that the deque can never produce.
// ----------------------------------------------------------------------------
module dq_checker import dq_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic signed [DATA_W-1:0] out_value_res,
  input logic [STAT_W-1:0]        out_status,
  input logic                     out_last,
  input logic [OCC_W-1:0]         out_occupancy
);

  // A list walk delivers one word every cycle until its final beat.
  a_list_streams: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("list walk broke off before its final beat");

  // Only a list of stored words gives beats that are not final.
  a_nonlast_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == ST_OK && out_occupancy != '0)
    else $error("non-final beat with error status or empty deque");

  // Underflow and empty list happen only on an empty deque and carry no word.
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_UNDERFLOW || out_status == ST_LIST_EMPTY)
    |-> out_occupancy == '0 && out_last && out_value_res == '0)
    else $error("empty-deque status with stored words or data");

  // Occupancy never exceeds the ring depth.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_occupancy) <= DEPTH)
    else $error("occupancy above ring depth");

endmodule

bind double_ended_queue_unit dq_checker u_dq_checker (.*);
